[sv/qrs_pkg.sv]
// qrs_pkg: shared types and constants for the quadratic root solver
`default_nettype none

package qrs_pkg;

	localparam int unsigned FRAC_BITS_DEF = 16;
	localparam int unsigned WORD_BITS_DEF = 32;
	localparam int unsigned TOL_BITS      = 31;
	localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(1);

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_ONE  = 2'd1,
		KIND_TWO  = 2'd2,
		KIND_INF  = 2'd3
	} kind_t;

	// which arithmetic the request takes through the pipeline
	typedef enum logic [2:0] {
		PATH_NONE,
		PATH_LIN,
		PATH_BZ,
		PATH_CZ,
		PATH_GEN,
		PATH_DZERO,
		PATH_DPOS
	} path_t;

	typedef struct packed {
		path_t path;
		kind_t kind;
		logic  an;
		logic  bn;
		logic  cn;
	} ctl_t;

	localparam int unsigned CTL_W = $bits(ctl_t);

endpackage

`default_nettype wire

[sv/qrs_div_pipe.sv]
// qrs_div_pipe: pipelined restoring divider, one quotient bit per stage
`default_nettype none

module qrs_div_pipe #(
	parameter int unsigned NUM_W = 48,
	parameter int unsigned DEN_W = 32,
	parameter int unsigned TAG_W = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	input  wire logic [TAG_W-1:0] tag,
	output logic                  out_valid,
	output logic      [NUM_W-1:0] quo,
	output logic      [TAG_W-1:0] out_tag
);

	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] nq_s  [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];
	logic [TAG_W-1:0] tag_s [NUM_W];
	logic             v_s   [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_step
		logic [DEN_W-1:0] rem_in;
		logic [NUM_W-1:0] nq_in;
		logic [DEN_W-1:0] den_in;
		logic [TAG_W-1:0] tag_in;
		logic             v_in;
		logic [DEN_W:0]   shifted;
		logic [DEN_W:0]   den_ext;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in  = num;
			assign den_in = den;
			assign tag_in = tag;
			assign v_in   = in_valid;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign nq_in  = nq_s[k-1];
			assign den_in = den_s[k-1];
			assign tag_in = tag_s[k-1];
			assign v_in   = v_s[k-1];
		end

		// shift in the next numerator bit and try the subtract
		assign shifted = {rem_in, nq_in[NUM_W-1]};
		assign den_ext = {1'b0, den_in};
		assign ge      = shifted >= den_ext;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DEN_W'(shifted - den_ext) : DEN_W'(shifted);
				nq_s[k]  <= {nq_in[NUM_W-2:0], ge};
				den_s[k] <= den_in;
				tag_s[k] <= tag_in;
			end
		end
	end

	assign out_valid = v_s[NUM_W-1];
	assign quo       = nq_s[NUM_W-1];
	assign out_tag   = tag_s[NUM_W-1];

endmodule

`default_nettype wire

[sv/quadratic_root_solver.sv]
// quadratic_root_solver: pipelined real-root solver for a*x^2 + b*x + c = 0
//
//  channel   signals                                      direction
//  input     in_valid, in_ready, coef_a, coef_b, coef_c   request in
//  output    out_valid, out_ready, root_kind, root_one,   result out
//            root_two, overflow
//  config    cfg_valid, cfg_ready, cfg_data               tolerance write
//
// one request per cycle while in_ready is high; a request passes stages 1 to 4,
// the c/a divider, the digit-by-digit square root pipeline, stage 5 and the
// two parallel root dividers into the result buffer; the bit-serial dividers
// and the square root pipeline give one result bit per stage
// a two-entry result buffer at the end holds results while out_ready is low;
// the whole pipeline advances only while that buffer has room
// reset clears valid bits, buffer pointers and sets the tolerance to 1
`default_nettype none

module quadratic_root_solver
	import qrs_pkg::*;
#(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
	parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [WORD_BITS-1:0] coef_a,
	input  wire logic signed [WORD_BITS-1:0] coef_b,
	input  wire logic signed [WORD_BITS-1:0] coef_c,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic             [1:0]           root_kind,
	output logic signed      [WORD_BITS-1:0] root_one,
	output logic signed      [WORD_BITS-1:0] root_two,
	output logic                             overflow,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic        [TOL_BITS-1:0]  cfg_data
);

	localparam int unsigned W   = WORD_BITS;
	localparam int unsigned F   = FRAC_BITS;
	localparam int unsigned CW  = (W > TOL_BITS) ? W : TOL_BITS;
	localparam int unsigned DW  = 2 * W + 1;           // discriminant
	localparam int unsigned NA  = W + 2 * F;           // c/a numerator
	localparam int unsigned SQW = (NA > DW) ? NA : DW;
	localparam int unsigned SQE = SQW + (SQW % 2);
	localparam int unsigned RW  = SQE / 2;             // root width
	localparam int unsigned NM  = W + 1;               // post-root numerator
	localparam int unsigned NB  = NM + F;
	localparam int unsigned TA  = CTL_W + 3 * W + DW;  // tag into c/a divider
	localparam int unsigned TS  = CTL_W + 3 * W;       // tag through root
	localparam int unsigned TB  = CTL_W + 1 + 2 * W + 1;

	localparam logic [W-1:0]  MIN_W  = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0]  MAX_W  = {1'b0, {(W-1){1'b1}}};
	localparam logic [NB-1:0] HALF_N = NB'(1) << (W - 1);
	localparam logic [RW-1:0] HALF_R = RW'(1) << (W - 1);

	// clamp a quotient magnitude to the word range: {overflow, value}
	function automatic logic [W:0] sat_fn(input logic neg, input logic [NB-1:0] mag);
		logic [NB-1:0] negq;
		negq = NB'(0) - mag;
		if (neg) begin
			sat_fn = (mag > HALF_N) ? {1'b1, MIN_W} : {1'b0, negq[W-1:0]};
		end else begin
			sat_fn = (mag >= HALF_N) ? {1'b1, MAX_W} : {1'b0, mag[W-1:0]};
		end
	endfunction

	logic [TOL_BITS-1:0] tol_q;
	logic [1:0]          cnt_q;
	logic                adv;

	// the pipeline moves as one while the result buffer has room
	assign adv       = cnt_q != 2'd2;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	// stage 1: capture the coefficients
	logic [W-1:0] a_s1, b_s1, c_s1;
	logic         v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1 <= coef_a;
			b_s1 <= coef_b;
			c_s1 <= coef_c;
		end
	end

	// stage 2: sign and magnitude, zero tests against the tolerance
	logic [W-1:0] am_n, bm_n, cm_n;
	logic [W-1:0] am_s2, bm_s2, cm_s2;
	logic         an_s2, bn_s2, cn_s2, az_s2, bz_s2, cz_s2, v_s2;

	assign am_n = a_s1[W-1] ? ({W{1'b0}} - a_s1) : a_s1;
	assign bm_n = b_s1[W-1] ? ({W{1'b0}} - b_s1) : b_s1;
	assign cm_n = c_s1[W-1] ? ({W{1'b0}} - c_s1) : c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			am_s2 <= am_n;
			bm_s2 <= bm_n;
			cm_s2 <= cm_n;
			an_s2 <= a_s1[W-1];
			bn_s2 <= b_s1[W-1];
			cn_s2 <= c_s1[W-1];
			// exact zero always counts, even with a zero tolerance
			az_s2 <= (am_n == '0) || (CW'(am_n) < CW'(tol_q));
			bz_s2 <= (bm_n == '0) || (CW'(bm_n) < CW'(tol_q));
			cz_s2 <= (cm_n == '0) || (CW'(cm_n) < CW'(tol_q));
		end
	end

	// stage 3: pick the path, form b^2 and a*c
	ctl_t           ctl_n2, ctl_s3;
	logic [W-1:0]   am_s3, bm_s3, cm_s3;
	logic [2*W-1:0] p_s3, q_s3;
	logic           v_s3;

	always_comb begin
		ctl_n2.an   = an_s2;
		ctl_n2.bn   = bn_s2;
		ctl_n2.cn   = cn_s2;
		ctl_n2.path = PATH_NONE;
		ctl_n2.kind = KIND_NONE;
		if (az_s2) begin
			// linear equation
			if (bz_s2 && cz_s2) begin
				ctl_n2.kind = KIND_INF;
			end else if (bz_s2) begin
				ctl_n2.kind = KIND_NONE;
			end else if (cz_s2) begin
				ctl_n2.kind = KIND_ONE;
			end else begin
				ctl_n2.kind = KIND_ONE;
				ctl_n2.path = PATH_LIN;
			end
		end else if (bz_s2) begin
			// pure square: roots are +-sqrt(-c/a) when signs differ
			if (cz_s2) begin
				ctl_n2.kind = KIND_ONE;
			end else if (an_s2 != cn_s2) begin
				ctl_n2.kind = KIND_TWO;
				ctl_n2.path = PATH_BZ;
			end
		end else if (cz_s2) begin
			ctl_n2.kind = KIND_TWO;
			ctl_n2.path = PATH_CZ;
		end else begin
			ctl_n2.path = PATH_GEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s3 <= ctl_n2;
			am_s3  <= am_s2;
			bm_s3  <= bm_s2;
			cm_s3  <= cm_s2;
			p_s3   <= bm_s2 * bm_s2;
			q_s3   <= am_s2 * cm_s2;
		end
	end

	// stage 4: discriminant with exact sign
	logic [2*W+1:0] p_ext, q4, d_sum, d_dif;
	ctl_t           ctl_n3, ctl_s4;
	logic [W-1:0]   am_s4, bm_s4, cm_s4;
	logic [DW-1:0]  d_s4;
	logic           v_s4;

	assign p_ext = (2*W+2)'(p_s3);
	assign q4    = {q_s3, 2'b00};
	assign d_sum = p_ext + q4;
	assign d_dif = p_ext - q4;

	always_comb begin
		ctl_n3 = ctl_s3;
		if (ctl_s3.path == PATH_GEN) begin
			if (ctl_s3.an != ctl_s3.cn || p_ext > q4) begin
				ctl_n3.path = PATH_DPOS;
				ctl_n3.kind = KIND_TWO;
			end else if (p_ext == q4) begin
				ctl_n3.path = PATH_DZERO;
				ctl_n3.kind = KIND_ONE;
			end else begin
				ctl_n3.path = PATH_NONE;
				ctl_n3.kind = KIND_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s4 <= ctl_n3;
			am_s4  <= am_s3;
			bm_s4  <= bm_s3;
			cm_s4  <= cm_s3;
			d_s4   <= (ctl_s3.an != ctl_s3.cn) ? DW'(d_sum) : DW'(d_dif);
		end
	end

	// c * 2^(2F) / a, used by the pure square case
	logic          va_out;
	logic [NA-1:0] qa_out;
	logic [TA-1:0] ta_out;

	qrs_div_pipe #(
		.NUM_W (NA),
		.DEN_W (W),
		.TAG_W (TA)
	) u_div_ca (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s4),
		.num       ({cm_s4, {(2*F){1'b0}}}),
		.den       (am_s4),
		.tag       ({ctl_s4, am_s4, bm_s4, cm_s4, d_s4}),
		.out_valid (va_out),
		.quo       (qa_out),
		.out_tag   (ta_out)
	);

	// square root pipeline, two radicand bits per stage
	ctl_t           ctl_a;
	logic [DW-1:0]  d_a;
	logic [SQE-1:0] rad0;

	assign ctl_a = ctl_t'(ta_out[TA-1 -: CTL_W]);
	assign d_a   = ta_out[DW-1:0];
	assign rad0  = (ctl_a.path == PATH_BZ) ? SQE'(qa_out) : SQE'(d_a);

	logic [RW+1:0]  sq_rem  [RW];
	logic [RW-1:0]  sq_root [RW];
	logic [SQE-1:0] sq_rad  [RW];
	logic [TS-1:0]  sq_tag  [RW];
	logic           sq_v    [RW];

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		logic [RW+1:0]  rem_in;
		logic [RW-1:0]  root_in;
		logic [SQE-1:0] rad_in;
		logic [TS-1:0]  tag_in;
		logic           v_in;
		logic [RW+3:0]  rem_sh;
		logic [RW+3:0]  trial;
		logic           ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad0;
			assign tag_in  = ta_out[TA-1 -: TS];
			assign v_in    = va_out;
		end else begin : g_next
			assign rem_in  = sq_rem[k-1];
			assign root_in = sq_root[k-1];
			assign rad_in  = sq_rad[k-1];
			assign tag_in  = sq_tag[k-1];
			assign v_in    = sq_v[k-1];
		end

		assign rem_sh = {rem_in, rad_in[SQE-1 -: 2]};
		assign trial  = (RW+4)'({root_in, 2'b01});
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k] <= 1'b0;
			end else if (adv) begin
				sq_v[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rem[k]  <= ge ? (RW+2)'(rem_sh - trial) : (RW+2)'(rem_sh);
				sq_root[k] <= {root_in[RW-2:0], ge};
				sq_rad[k]  <= {rad_in[SQE-3:0], 2'b00};
				sq_tag[k]  <= tag_in;
			end
		end
	end

	// stage 5: numerators and divisors for the two root dividers
	ctl_t          ctl_r;
	logic [W-1:0]  am_r, bm_r, cm_r;
	logic [RW-1:0] s_r, s_neg;
	logic [W:0]    s_t, bm_x, b_plus_s, b_minus_s, s_minus_b;
	logic          b_ge_s;

	assign ctl_r     = ctl_t'(sq_tag[RW-1][TS-1 -: CTL_W]);
	assign am_r      = sq_tag[RW-1][3*W-1 -: W];
	assign bm_r      = sq_tag[RW-1][2*W-1 -: W];
	assign cm_r      = sq_tag[RW-1][W-1:0];
	assign s_r       = sq_root[RW-1];
	assign s_neg     = RW'(0) - s_r;
	assign s_t       = s_r[W:0];
	assign bm_x      = {1'b0, bm_r};
	assign b_plus_s  = bm_x + s_t;
	assign b_minus_s = bm_x - s_t;
	assign s_minus_b = s_t - bm_x;
	assign b_ge_s    = bm_x >= s_t;

	logic [NM-1:0] numb_n, numc_n;
	logic [W:0]    denb_n, denc_n;
	logic          negb_n, negc_n;

	always_comb begin
		numb_n = '0;
		numc_n = '0;
		denb_n = {am_r, 1'b0};
		denc_n = {am_r, 1'b0};
		negb_n = 1'b0;
		negc_n = 1'b0;
		case (ctl_r.path)
			PATH_LIN: begin
				// -c/b
				numb_n = NM'(cm_r);
				denb_n = {1'b0, bm_r};
				negb_n = ctl_r.cn == ctl_r.bn;
			end
			PATH_CZ: begin
				// -b/a
				numc_n = NM'(bm_r);
				denc_n = {1'b0, am_r};
				negc_n = ctl_r.bn == ctl_r.an;
			end
			PATH_DZERO: begin
				numb_n = NM'(bm_r);
				negb_n = (!ctl_r.bn) != ctl_r.an;
			end
			PATH_DPOS: begin
				// signed-magnitude -b - s and -b + s
				if (!ctl_r.bn) begin
					numb_n = b_plus_s;
					negb_n = !ctl_r.an;
					numc_n = b_ge_s ? b_minus_s : s_minus_b;
					negc_n = b_ge_s ? !ctl_r.an : ctl_r.an;
				end else begin
					numb_n = b_ge_s ? b_minus_s : s_minus_b;
					negb_n = b_ge_s ? ctl_r.an : !ctl_r.an;
					numc_n = b_plus_s;
					negc_n = ctl_r.an;
				end
			end
			default: begin
				numb_n = '0;
			end
		endcase
	end

	ctl_t          ctl_s5;
	logic [NM-1:0] numb_s5, numc_s5;
	logic [W:0]    denb_s5, denc_s5;
	logic          negb_s5, negc_s5, bzovf_s5, v_s5;
	logic [W-1:0]  bzr1_s5, bzr2_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= sq_v[RW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s5   <= ctl_r;
			numb_s5  <= numb_n;
			numc_s5  <= numc_n;
			denb_s5  <= denb_n;
			denc_s5  <= denc_n;
			negb_s5  <= negb_n;
			negc_s5  <= negc_n;
			// pure square roots need no divide: clamp +s and -s here
			bzr1_s5  <= (s_r >= HALF_R) ? MAX_W : s_r[W-1:0];
			bzr2_s5  <= (s_r > HALF_R) ? MIN_W : s_neg[W-1:0];
			bzovf_s5 <= s_r >= HALF_R;
		end
	end

	// root dividers, one for each root
	logic          vb_out, vc_out;
	logic [NB-1:0] qb_out, qc_out;
	logic [TB-1:0] tb_out;
	logic          negc_out;

	qrs_div_pipe #(
		.NUM_W (NB),
		.DEN_W (W + 1),
		.TAG_W (TB)
	) u_div_r1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s5),
		.num       ({numb_s5, {F{1'b0}}}),
		.den       (denb_s5),
		.tag       ({ctl_s5, negb_s5, bzr1_s5, bzr2_s5, bzovf_s5}),
		.out_valid (vb_out),
		.quo       (qb_out),
		.out_tag   (tb_out)
	);

	qrs_div_pipe #(
		.NUM_W (NB),
		.DEN_W (W + 1),
		.TAG_W (1)
	) u_div_r2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s5),
		.num       ({numc_s5, {F{1'b0}}}),
		.den       (denc_s5),
		.tag       (negc_s5),
		.out_valid (vc_out),
		.quo       (qc_out),
		.out_tag   (negc_out)
	);

	// final selection and clamping
	ctl_t         ctl_f;
	logic         negb_f, bzovf_f;
	logic [W-1:0] bzr1_f, bzr2_f;
	logic [W:0]   sat_b, sat_c;
	logic [W-1:0] r1_f, r2_f;
	logic         ovf_f;

	assign ctl_f   = ctl_t'(tb_out[TB-1 -: CTL_W]);
	assign negb_f  = tb_out[2*W+1];
	assign bzr1_f  = tb_out[2*W:W+1];
	assign bzr2_f  = tb_out[W:1];
	assign bzovf_f = tb_out[0];
	assign sat_b   = sat_fn(negb_f, qb_out);
	assign sat_c   = sat_fn(negc_out, qc_out);

	always_comb begin
		r1_f  = '0;
		r2_f  = '0;
		ovf_f = 1'b0;
		case (ctl_f.path)
			PATH_LIN, PATH_DZERO: begin
				r1_f  = sat_b[W-1:0];
				ovf_f = sat_b[W];
			end
			PATH_BZ: begin
				r1_f  = bzr1_f;
				r2_f  = bzr2_f;
				ovf_f = bzovf_f;
			end
			PATH_CZ: begin
				r2_f  = sat_c[W-1:0];
				ovf_f = sat_c[W];
			end
			PATH_DPOS: begin
				r1_f  = sat_b[W-1:0];
				r2_f  = sat_c[W-1:0];
				ovf_f = sat_b[W] | sat_c[W];
			end
			default: begin
				ovf_f = 1'b0;
			end
		endcase
	end

	// two-entry result buffer
	kind_t        ent_kind_q [2];
	logic [W-1:0] ent_one_q  [2];
	logic [W-1:0] ent_two_q  [2];
	logic         ent_ovf_q  [2];
	logic         wr_q, rd_q, push, pop;

	assign push = adv && vb_out;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_kind_q[wr_q] <= ctl_f.kind;
			ent_one_q[wr_q]  <= r1_f;
			ent_two_q[wr_q]  <= r2_f;
			ent_ovf_q[wr_q]  <= ovf_f;
		end
	end

	assign out_valid = cnt_q != 2'd0;
	assign root_kind = ent_kind_q[rd_q];
	assign root_one  = ent_one_q[rd_q];
	assign root_two  = ent_two_q[rd_q];
	assign overflow  = ent_ovf_q[rd_q];

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result buffer count out of range");

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		vb_out == vc_out)
		else $error("root dividers out of step");

	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && root_kind == KIND_NONE) |->
		(root_one == '0 && root_two == '0 && !overflow))
		else $error("no-root result carries root data");

	a_inf_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && root_kind == KIND_INF) |->
		(root_one == '0 && root_two == '0 && !overflow))
		else $error("infinite-root result carries root data");

	a_one_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && root_kind == KIND_ONE) |-> (root_two == '0))
		else $error("single-root result carries a second root");
`endif

endmodule

`default_nettype wire
